FILE: src/sfc_pkg.sv
// Shared widths, register indexes, reset values and types of the sphere culling pipeline.
`default_nettype none
package sfc_pkg;

   // Field widths
   localparam int COORD_W = 20;              // Q11.8 coordinate
   localparam int OFS_W   = COORD_W + 1;     // camera-relative offset
   localparam int AXIS_W  = 16;              // Q1.14 axis component
   localparam int PROD_W  = OFS_W + AXIS_W;  // one offset-axis product
   localparam int DOT_W   = PROD_W + 2;      // sum of three products, Q.22
   localparam int RAD_W   = COORD_W - 1;     // magnitude of a non-negative radius
   localparam int DEPTH_W = 20;              // near and far, Q12.8
   localparam int SLOPE_W = 20;              // tangent and secant, Q8.12
   localparam int NUM_AXES = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;
   localparam int CAM_W      = 3 * COORD_W;
   localparam int AXES_W     = 3 * AXIS_W;
   localparam int RANGE_W    = 2 * DEPTH_W;
   localparam int SLOPES_W   = 2 * SLOPE_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_POSITION  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_AXIS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_AXIS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_AXIS          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_RANGE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTICAL_SLOPE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZONTAL_SLOPE = 3'd6;

   // Reset values
   localparam logic [CAM_W-1:0]    CAMERA_RESET  = 60'd0;
   localparam logic [AXES_W-1:0]   FORWARD_RESET = 48'd70368744177664;
   localparam logic [AXES_W-1:0]   RIGHT_RESET   = 48'd49152;
   localparam logic [AXES_W-1:0]   UP_RESET      = 48'd1073741824;
   localparam logic [RANGE_W-1:0]  RANGE_RESET   = 40'd1099510579200;
   localparam logic [SLOPES_W-1:0] SLOPE_RESET   = 40'd6074404864;

   // Projection order inside the pipeline
   localparam int AX_FORWARD = 0;
   localparam int AX_UP      = 1;
   localparam int AX_RIGHT   = 2;

   // Depth and slope settings seen by the test stages
   typedef struct packed {
      logic [DEPTH_W-1:0] near_q;
      logic [DEPTH_W-1:0] far_q;    // already max(near, far)
      logic [SLOPE_W-1:0] tan_v;
      logic [SLOPE_W-1:0] sec_v;
      logic [SLOPE_W-1:0] tan_h;
      logic [SLOPE_W-1:0] sec_h;
   } sfc_cfg_type;

endpackage
`default_nettype wire

FILE: src/sphere_frustum_cull.sv
// Top level of the bounding-sphere frustum culling pipeline with its settings registers.
`default_nettype none
// One bounding sphere enters per cycle and its visible flag leaves after the last
// stage through the output register; with rsp_ready held high the block sustains
// one item per clock. The five stages are: camera offset, the nine offset-axis
// multiplies, the three dot sums, the depth test with the split depth-times-tangent
// and radius-times-secant multiplies, and the slope compare. A low rsp_ready
// holds every stage in place and an empty stage still fills, so nothing is lost.
// Settings are written through the csr_ port and take effect at once; write them
// only while no item is in flight.
module sphere_frustum_cull (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [sfc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sfc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [sfc_pkg::COORD_W-1:0]  req_center_x,
   input  wire logic signed [sfc_pkg::COORD_W-1:0]  req_center_y,
   input  wire logic signed [sfc_pkg::COORD_W-1:0]  req_center_z,
   input  wire logic signed [sfc_pkg::COORD_W-1:0]  req_sphere_radius,
   input  wire logic                                req_bounds_valid,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_visible
);
   import sfc_pkg::*;

   logic [CAM_W-1:0]    camera_ff;
   logic [AXES_W-1:0]   forward_ff, right_ff, up_ff;
   logic [RANGE_W-1:0]  range_ff;
   logic [SLOPES_W-1:0] vslope_ff, hslope_ff;
   sfc_cfg_type         cfg;

   logic                     o_valid, o_ready;
   logic signed [OFS_W-1:0]  ofs_x, ofs_y, ofs_z;
   logic [RAD_W-1:0]         o_rad, p_rad;
   logic                     o_skip, p_skip;
   logic                     p_valid, p_ready;
   logic signed [DOT_W-1:0]  depth, lat_v, lat_h;

   // Write the settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         camera_ff  <= CAMERA_RESET;
         forward_ff <= FORWARD_RESET;
         right_ff   <= RIGHT_RESET;
         up_ff      <= UP_RESET;
         range_ff   <= RANGE_RESET;
         vslope_ff  <= SLOPE_RESET;
         hslope_ff  <= SLOPE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CAMERA_POSITION:  camera_ff  <= csr_wdata[CAM_W-1:0];
            CSR_FORWARD_AXIS:     forward_ff <= csr_wdata[AXES_W-1:0];
            CSR_RIGHT_AXIS:       right_ff   <= csr_wdata[AXES_W-1:0];
            CSR_UP_AXIS:          up_ff      <= csr_wdata[AXES_W-1:0];
            CSR_DEPTH_RANGE:      range_ff   <= csr_wdata[RANGE_W-1:0];
            CSR_VERTICAL_SLOPE:   vslope_ff  <= csr_wdata[SLOPES_W-1:0];
            CSR_HORIZONTAL_SLOPE: hslope_ff  <= csr_wdata[SLOPES_W-1:0];
            default: ;
         endcase
      end
   end

   // Unpack depth and slope settings; clamp far to at least near
   always_comb begin
      cfg.near_q = range_ff[DEPTH_W-1:0];
      cfg.far_q  = (range_ff[RANGE_W-1:DEPTH_W] < range_ff[DEPTH_W-1:0]) ?
                   range_ff[DEPTH_W-1:0] : range_ff[RANGE_W-1:DEPTH_W];
      cfg.tan_v  = vslope_ff[SLOPE_W-1:0];
      cfg.sec_v  = vslope_ff[SLOPES_W-1:SLOPE_W];
      cfg.tan_h  = hslope_ff[SLOPE_W-1:0];
      cfg.sec_h  = hslope_ff[SLOPES_W-1:SLOPE_W];
   end

   sfc_offset u_offset (
      .clock        (clock),
      .reset        (reset),
      .camera       (camera_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .center_x     (req_center_x),
      .center_y     (req_center_y),
      .center_z     (req_center_z),
      .radius       (req_sphere_radius),
      .bounds_valid (req_bounds_valid),
      .out_valid    (o_valid),
      .out_ready    (o_ready),
      .ofs_x        (ofs_x),
      .ofs_y        (ofs_y),
      .ofs_z        (ofs_z),
      .rad          (o_rad),
      .skip         (o_skip)
   );

   sfc_project u_project (
      .clock        (clock),
      .reset        (reset),
      .forward_axis (forward_ff),
      .up_axis      (up_ff),
      .right_axis   (right_ff),
      .in_valid     (o_valid),
      .in_ready     (o_ready),
      .ofs_x        (ofs_x),
      .ofs_y        (ofs_y),
      .ofs_z        (ofs_z),
      .rad_i        (o_rad),
      .skip_i       (o_skip),
      .out_valid    (p_valid),
      .out_ready    (p_ready),
      .depth        (depth),
      .lat_v        (lat_v),
      .lat_h        (lat_h),
      .rad_o        (p_rad),
      .skip_o       (p_skip)
   );

   sfc_test u_test (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .depth     (depth),
      .lat_v     (lat_v),
      .lat_h     (lat_h),
      .rad       (p_rad),
      .skip      (p_skip),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .visible   (rsp_visible)
   );
endmodule
`default_nettype wire

FILE: src/sfc_offset.sv
// First stage: offset from the camera and always-visible flag.
`default_nettype none
module sfc_offset (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [sfc_pkg::CAM_W-1:0]         camera,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic signed [sfc_pkg::COORD_W-1:0] center_x,
   input  wire logic signed [sfc_pkg::COORD_W-1:0] center_y,
   input  wire logic signed [sfc_pkg::COORD_W-1:0] center_z,
   input  wire logic signed [sfc_pkg::COORD_W-1:0] radius,
   input  wire logic                              bounds_valid,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [sfc_pkg::OFS_W-1:0]       ofs_x,
   output logic signed [sfc_pkg::OFS_W-1:0]       ofs_y,
   output logic signed [sfc_pkg::OFS_W-1:0]       ofs_z,
   output logic [sfc_pkg::RAD_W-1:0]              rad,
   output logic                                   skip
);
   import sfc_pkg::*;

   logic                     valid_ff;
   logic                     adv;
   logic signed [OFS_W-1:0]  ofs_x_ff, ofs_y_ff, ofs_z_ff;
   logic signed [OFS_W-1:0]  ofs_x_in, ofs_y_in, ofs_z_in;
   logic [RAD_W-1:0]         rad_ff;
   logic                     skip_ff, skip_in;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   // Subtract the camera position per component
   always_comb begin
      ofs_x_in = OFS_W'(center_x) - OFS_W'($signed(camera[0*COORD_W +: COORD_W]));
      ofs_y_in = OFS_W'(center_y) - OFS_W'($signed(camera[1*COORD_W +: COORD_W]));
      ofs_z_in = OFS_W'(center_z) - OFS_W'($signed(camera[2*COORD_W +: COORD_W]));
      skip_in  = !bounds_valid || radius[COORD_W-1];
   end

   // Advance the stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload on an accepted item
   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         ofs_x_ff <= ofs_x_in;
         ofs_y_ff <= ofs_y_in;
         ofs_z_ff <= ofs_z_in;
         rad_ff   <= radius[RAD_W-1:0];
         skip_ff  <= skip_in;
      end
   end

   assign out_valid = valid_ff;
   assign ofs_x     = ofs_x_ff;
   assign ofs_y     = ofs_y_ff;
   assign ofs_z     = ofs_z_ff;
   assign rad       = rad_ff;
   assign skip      = skip_ff;
endmodule
`default_nettype wire

FILE: src/sfc_project.sv
// Second and third stages: offset-axis products, then the three dot sums.
`default_nettype none
module sfc_project (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [sfc_pkg::AXES_W-1:0]        forward_axis,
   input  wire logic [sfc_pkg::AXES_W-1:0]        up_axis,
   input  wire logic [sfc_pkg::AXES_W-1:0]        right_axis,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic signed [sfc_pkg::OFS_W-1:0]  ofs_x,
   input  wire logic signed [sfc_pkg::OFS_W-1:0]  ofs_y,
   input  wire logic signed [sfc_pkg::OFS_W-1:0]  ofs_z,
   input  wire logic [sfc_pkg::RAD_W-1:0]         rad_i,
   input  wire logic                              skip_i,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [sfc_pkg::DOT_W-1:0]       depth,
   output logic signed [sfc_pkg::DOT_W-1:0]       lat_v,
   output logic signed [sfc_pkg::DOT_W-1:0]       lat_h,
   output logic [sfc_pkg::RAD_W-1:0]              rad_o,
   output logic                                   skip_o
);
   import sfc_pkg::*;

   logic                     p_valid_ff, d_valid_ff;
   logic                     p_adv, d_adv;
   logic [AXES_W-1:0]        axes [NUM_AXES];
   logic signed [OFS_W-1:0]  ofs [3];
   logic signed [PROD_W-1:0] prod_in [NUM_AXES][3];
   logic signed [PROD_W-1:0] prod_ff [NUM_AXES][3];
   logic signed [DOT_W-1:0]  dot_in [NUM_AXES];
   logic signed [DOT_W-1:0]  dot_ff [NUM_AXES];
   logic [RAD_W-1:0]         p_rad_ff, d_rad_ff;
   logic                     p_skip_ff, d_skip_ff;

   assign d_adv    = !d_valid_ff || out_ready;
   assign p_adv    = !p_valid_ff || d_adv;
   assign in_ready = p_adv;

   assign axes[AX_FORWARD] = forward_axis;
   assign axes[AX_UP]      = up_axis;
   assign axes[AX_RIGHT]   = right_axis;
   assign ofs[0] = ofs_x;
   assign ofs[1] = ofs_y;
   assign ofs[2] = ofs_z;

   // Form all nine products in parallel
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[a][c] = PROD_W'(ofs[c]) *
                            PROD_W'($signed(axes[a][c*AXIS_W +: AXIS_W]));
         end
      end
   end

   // Sum each axis
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         dot_in[a] = DOT_W'(prod_ff[a][0]) + DOT_W'(prod_ff[a][1]) + DOT_W'(prod_ff[a][2]);
      end
   end

   // Advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (p_adv) begin
            p_valid_ff <= in_valid;
         end
         if (d_adv) begin
            d_valid_ff <= p_valid_ff;
         end
      end
   end

   // Load products, then sums
   always_ff @(posedge clock) begin
      if (p_adv && in_valid) begin
         prod_ff   <= prod_in;
         p_rad_ff  <= rad_i;
         p_skip_ff <= skip_i;
      end
      if (d_adv && p_valid_ff) begin
         dot_ff    <= dot_in;
         d_rad_ff  <= p_rad_ff;
         d_skip_ff <= p_skip_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign depth     = dot_ff[AX_FORWARD];
   assign lat_v     = dot_ff[AX_UP];
   assign lat_h     = dot_ff[AX_RIGHT];
   assign rad_o     = d_rad_ff;
   assign skip_o    = d_skip_ff;
endmodule
`default_nettype wire

FILE: src/sfc_test.sv
// Fourth and fifth stages: depth test and slope partial products, then slope compare.
`default_nettype none
module sfc_test (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sfc_pkg::sfc_cfg_type             cfg,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic signed [sfc_pkg::DOT_W-1:0] depth,
   input  wire logic signed [sfc_pkg::DOT_W-1:0] lat_v,
   input  wire logic signed [sfc_pkg::DOT_W-1:0] lat_h,
   input  wire logic [sfc_pkg::RAD_W-1:0]        rad,
   input  wire logic                             skip,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic                                  visible
);
   import sfc_pkg::*;

   localparam int LO_W   = 20;                      // low slice of depth
   localparam int HI_W   = DOT_W - LO_W;            // signed high slice
   localparam int PLO_W  = LO_W + SLOPE_W;
   localparam int PHI_W  = HI_W + SLOPE_W + 1;
   localparam int RSEC_W = RAD_W + SLOPE_W;
   localparam int RHS_W  = PHI_W + LO_W + 2;
   localparam int CMP_W  = DOT_W + 2;
   localparam int R_SH   = 14;                      // Q.8 to Q.22

   logic                      t_valid_ff, o_valid_ff;
   logic                      t_adv, o_adv;

   // Depth test
   logic signed [CMP_W-1:0]   r22, near22, far22, d_plus, d_minus;
   logic                      cull_depth_in, cull_depth_ff;
   // Slope partial products
   logic [LO_W-1:0]           dep_lo;
   logic signed [HI_W-1:0]    dep_hi;
   logic [PLO_W-1:0]          plo_v_in, plo_h_in, plo_v_ff, plo_h_ff;
   logic signed [PHI_W-1:0]   phi_v_in, phi_h_in, phi_v_ff, phi_h_ff;
   logic [RSEC_W-1:0]         rsec_v_in, rsec_h_in, rsec_v_ff, rsec_h_ff;
   logic [DOT_W-1:0]          abs_v_in, abs_h_in, abs_v_ff, abs_h_ff;
   logic                      t_skip_ff;
   // Slope compare
   logic signed [RHS_W-1:0]   rhs_v, rhs_h, lhs_v, lhs_h;
   logic                      visible_in, visible_ff;

   assign o_adv    = !o_valid_ff || out_ready;
   assign t_adv    = !t_valid_ff || o_adv;
   assign in_ready = t_adv;

   // Compare the sphere extent with near and far at Q.22
   always_comb begin
      r22     = CMP_W'({rad, {R_SH{1'b0}}});
      near22  = CMP_W'({cfg.near_q, {R_SH{1'b0}}});
      far22   = CMP_W'({cfg.far_q, {R_SH{1'b0}}});
      d_plus  = CMP_W'(depth) + r22;
      d_minus = CMP_W'(depth) - r22;
      cull_depth_in = (d_plus < near22) || (d_minus > far22);
   end

   // Split depth times tangent; radius times secant; lateral magnitudes
   always_comb begin
      dep_lo    = depth[LO_W-1:0];
      dep_hi    = depth[DOT_W-1:LO_W];
      plo_v_in  = PLO_W'(dep_lo) * PLO_W'(cfg.tan_v);
      plo_h_in  = PLO_W'(dep_lo) * PLO_W'(cfg.tan_h);
      phi_v_in  = PHI_W'(dep_hi) * PHI_W'($signed({1'b0, cfg.tan_v}));
      phi_h_in  = PHI_W'(dep_hi) * PHI_W'($signed({1'b0, cfg.tan_h}));
      rsec_v_in = RSEC_W'(rad) * RSEC_W'(cfg.sec_v);
      rsec_h_in = RSEC_W'(rad) * RSEC_W'(cfg.sec_h);
      abs_v_in  = lat_v[DOT_W-1] ? DOT_W'(-lat_v) : DOT_W'(lat_v);
      abs_h_in  = lat_h[DOT_W-1] ? DOT_W'(-lat_h) : DOT_W'(lat_h);
   end

   // Reassemble both slope bounds at Q.34 and compare
   always_comb begin
      rhs_v = (RHS_W'(phi_v_ff) <<< LO_W) + RHS_W'(plo_v_ff) + RHS_W'({rsec_v_ff, {R_SH{1'b0}}});
      rhs_h = (RHS_W'(phi_h_ff) <<< LO_W) + RHS_W'(plo_h_ff) + RHS_W'({rsec_h_ff, {R_SH{1'b0}}});
      lhs_v = RHS_W'({abs_v_ff, 12'd0});
      lhs_h = RHS_W'({abs_h_ff, 12'd0});
      visible_in = t_skip_ff || !(cull_depth_ff || (lhs_v > rhs_v) || (lhs_h > rhs_h));
   end

   // Advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (t_adv) begin
            t_valid_ff <= in_valid;
         end
         if (o_adv) begin
            o_valid_ff <= t_valid_ff;
         end
      end
   end

   // Load partial products, then the result item
   always_ff @(posedge clock) begin
      if (t_adv && in_valid) begin
         cull_depth_ff <= cull_depth_in;
         plo_v_ff      <= plo_v_in;
         plo_h_ff      <= plo_h_in;
         phi_v_ff      <= phi_v_in;
         phi_h_ff      <= phi_h_in;
         rsec_v_ff     <= rsec_v_in;
         rsec_h_ff     <= rsec_h_in;
         abs_v_ff      <= abs_v_in;
         abs_h_ff      <= abs_h_in;
         t_skip_ff     <= skip;
      end
      if (o_adv && t_valid_ff) begin
         visible_ff <= visible_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign visible   = visible_ff;
endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for sphere_frustum_cull: directed and random spheres checked against a predictor.
`timescale 1ns / 1ps
module tb;
   import sfc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int RANDOM_PHASES = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REGISTER = 3'd7;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] cz;
      logic [COORD_W-1:0] radius;
      logic               valid;
   } sphere_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [COORD_W-1:0] req_center_x = '0;
   logic [COORD_W-1:0] req_center_y = '0;
   logic [COORD_W-1:0] req_center_z = '0;
   logic [COORD_W-1:0] req_sphere_radius = '0;
   logic req_bounds_valid = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_visible;

   // Shadow copy of the settings registers
   logic [CAM_W-1:0]    cam_reg;
   logic [AXES_W-1:0]   fwd_reg;
   logic [AXES_W-1:0]   right_reg;
   logic [AXES_W-1:0]   up_reg;
   logic [RANGE_W-1:0]  range_reg;
   logic [SLOPES_W-1:0] vslope_reg;
   logic [SLOPES_W-1:0] hslope_reg;

   bit visible_queue[$];
   bit want_visible;
   int error_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   sphere_frustum_cull u_dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .req_center_z(req_center_z),
      .req_sphere_radius(req_sphere_radius),
      .req_bounds_valid(req_bounds_valid),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_visible(rsp_visible)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Project a camera offset on one packed Q1.14 axis; the result is Q.22
   function automatic longint project(longint ox, longint oy, longint oz,
                                      logic [AXES_W-1:0] axis);
      return ox * longint'($signed(axis[15:0])) + oy * longint'($signed(axis[31:16]))
           + oz * longint'($signed(axis[47:32]));
   endfunction

   // Compare the lateral distance against the slope widened by the radius, at Q.34
   function automatic bit beyond_slope(longint lateral, longint depth, longint rad,
                                       logic [SLOPES_W-1:0] slope);
      longint mag;
      mag = (lateral < 0) ? -lateral : lateral;
      return mag * 4096 > depth * longint'(slope[19:0])
                          + rad * longint'(slope[39:20]) * 16384;
   endfunction

   function automatic bit predict_visible(sphere_type s);
      longint rad, ox, oy, oz, depth, near_q, far_q, r22;
      rad = longint'($signed(s.radius));
      if (!s.valid || rad < 0) return 1'b1;
      ox = longint'($signed(s.cx)) - longint'($signed(cam_reg[19:0]));
      oy = longint'($signed(s.cy)) - longint'($signed(cam_reg[39:20]));
      oz = longint'($signed(s.cz)) - longint'($signed(cam_reg[59:40]));
      depth = project(ox, oy, oz, fwd_reg);
      near_q = longint'(range_reg[19:0]);
      far_q = longint'(range_reg[39:20]);
      if (far_q < near_q) far_q = near_q;
      r22 = rad * 16384;
      if (depth + r22 < near_q * 16384 || depth - r22 > far_q * 16384) return 1'b0;
      if (beyond_slope(project(ox, oy, oz, up_reg), depth, rad, vslope_reg) ||
          beyond_slope(project(ox, oy, oz, right_reg), depth, rad, hslope_reg))
         return 1'b0;
      return 1'b1;
   endfunction

   function automatic sphere_type sph(int cx, int cy, int cz, int r, bit v);
      sphere_type s;
      s.cx = cx[COORD_W-1:0];
      s.cy = cy[COORD_W-1:0];
      s.cz = cz[COORD_W-1:0];
      s.radius = r[COORD_W-1:0];
      s.valid = v;
      return s;
   endfunction

   // Mostly valid spheres near the camera, with some anywhere and some gated off
   function automatic sphere_type random_sphere();
      sphere_type s;
      int pick;
      int off;
      s.valid = ($urandom_range(99) < 92);
      pick = $urandom_range(99);
      if (pick < 15)
         s.radius = {1'b1, 19'($urandom())};
      else if (pick < 85)
         s.radius = 20'($urandom_range(0, 2048));
      else
         s.radius = {1'b0, 19'($urandom())};
      if ($urandom_range(99) < 40) begin
         s.cx = 20'($urandom());
         s.cy = 20'($urandom());
         s.cz = 20'($urandom());
      end else begin
         off = $urandom_range(0, 16383) - 8192;
         s.cx = cam_reg[19:0] + off[19:0];
         off = $urandom_range(0, 16383) - 8192;
         s.cy = cam_reg[39:20] + off[19:0];
         off = $urandom_range(0, 16383) - 8192;
         s.cz = cam_reg[59:40] + off[19:0];
      end
      return s;
   endfunction

   function automatic logic [AXES_W-1:0] unit_axis(int k, bit neg);
      logic [AXES_W-1:0] a;
      a = '0;
      a[16*k +: 16] = neg ? 16'hC000 : 16'h4000;
      return a;
   endfunction

   task automatic set_idling(idle_mode_type m);
      sender_idle_pct = (m == IDLE_SENDER) ? 72 : (m == IDLE_BOTH) ? 16 : 0;
      receiver_stall_pct = (m == IDLE_RECEIVER) ? 72 : (m == IDLE_BOTH) ? 16 : 0;
   endtask

   // Write one register with the enable held for a single cycle, and update the shadow copy
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CAMERA_POSITION:  cam_reg = data[CAM_W-1:0];
         CSR_FORWARD_AXIS:     fwd_reg = data[AXES_W-1:0];
         CSR_RIGHT_AXIS:       right_reg = data[AXES_W-1:0];
         CSR_UP_AXIS:          up_reg = data[AXES_W-1:0];
         CSR_DEPTH_RANGE:      range_reg = data[RANGE_W-1:0];
         CSR_VERTICAL_SLOPE:   vslope_reg = data[SLOPES_W-1:0];
         CSR_HORIZONTAL_SLOPE: hslope_reg = data[SLOPES_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one item, optionally after an idle gap, and queue its prediction on accept
   task automatic send_sphere(sphere_type s);
      int gap;
      gap = 0;
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_center_x <= s.cx;
      req_center_y <= s.cy;
      req_center_z <= s.cz;
      req_sphere_radius <= s.radius;
      req_bounds_valid <= s.valid;
      do @(posedge clock); while (!req_ready);
      visible_queue.push_back(predict_visible(s));
   endtask

   // Drop valid and wait until every result is back and the pipeline is empty
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (visible_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Gating, near plane, side slopes and field extremes at the reset settings
   task automatic test_reset_defaults();
      set_idling(IDLE_BOTH);
      send_sphere(sph('h7FFFF, 'h7FFFF, 'h7FFFF, 'h7FFFF, 1'b0));
      send_sphere(sph(0, 0, -4096, -1, 1'b1));
      send_sphere(sph(0, 0, -4096, 'h80000, 1'b1));
      send_sphere(sph(0, 0, 0, 0, 1'b1));
      send_sphere(sph(0, 0, -256, 0, 1'b1));
      send_sphere(sph(0, 0, -256, 256, 1'b1));
      send_sphere(sph(0, 0, -257, 256, 1'b1));
      send_sphere(sph(0, 256, 256, 0, 1'b1));
      send_sphere(sph(0, 257, 256, 0, 1'b1));
      send_sphere(sph(-300, 0, 256, 0, 1'b1));
      send_sphere(sph(400, 0, 256, 200, 1'b1));
      send_sphere(sph('h7FFFF, 'h7FFFF, 'h7FFFF, 'h7FFFF, 1'b1));
      send_sphere(sph('h80000, 'h80000, 'h80000, 0, 1'b1));
      wait_for_results();
   endtask

   // Far plane contact, far below near, and the extreme depth range
   task automatic test_depth_planes();
      set_idling(IDLE_NONE);
      csr_write(CSR_DEPTH_RANGE, (60'd512 << 20) | 60'd256);
      send_sphere(sph(0, 0, 768, 256, 1'b1));
      send_sphere(sph(0, 0, 769, 256, 1'b1));
      send_sphere(sph(0, 0, 0, 256, 1'b1));
      wait_for_results();
      csr_write(CSR_DEPTH_RANGE, (60'd256 << 20) | 60'd512);
      send_sphere(sph(0, 0, 512, 0, 1'b1));
      send_sphere(sph(0, 0, 513, 0, 1'b1));
      send_sphere(sph(0, 0, 511, 0, 1'b1));
      wait_for_results();
      csr_write(CSR_DEPTH_RANGE, 60'hFFFFF);
      send_sphere(sph(0, 0, 'h7FFFF, 'h7FFFF, 1'b1));
      send_sphere(sph(0, 0, 'h7FFFF, 0, 1'b1));
      wait_for_results();
   endtask

   // Random spheres over a series of settings: all zero, all ones, view-like, raw
   task automatic test_random_settings();
      int f, u;
      logic [CSR_DATA_W-1:0] raw;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_idling(idle_mode_type'(p % 4));
         if (p == 0 || p == 1) begin
            raw = (p == 0) ? '0 : '1;
            for (int i = 0; i <= int'(CSR_HORIZONTAL_SLOPE); i++)
               csr_write(CSR_IDX_W'(i), raw);
         end else if (p % 2 == 0) begin
            f = $urandom_range(2);
            u = (f + 1 + $urandom_range(1)) % 3;
            csr_write(CSR_CAMERA_POSITION, CSR_DATA_W'({$urandom(), $urandom()}));
            csr_write(CSR_FORWARD_AXIS,
                      CSR_DATA_W'(unit_axis(f, 1'($urandom_range(1)))));
            csr_write(CSR_UP_AXIS,
                      CSR_DATA_W'(unit_axis(u, 1'($urandom_range(1)))));
            csr_write(CSR_RIGHT_AXIS,
                      CSR_DATA_W'(unit_axis(3 - f - u, 1'($urandom_range(1)))));
            csr_write(CSR_DEPTH_RANGE, CSR_DATA_W'({20'($urandom_range(1024, 20'hFFFFF)),
                                                    20'($urandom_range(0, 1024))}));
            csr_write(CSR_VERTICAL_SLOPE,
                      CSR_DATA_W'({20'($urandom_range(16'h1000, 16'h2000)),
                                   20'($urandom_range(16'h0800, 16'h4000))}));
            csr_write(CSR_HORIZONTAL_SLOPE,
                      CSR_DATA_W'({20'($urandom_range(16'h1000, 16'h2000)),
                                   20'($urandom_range(16'h0800, 16'h4000))}));
         end else begin
            // Full-width data, high bits included; axes left unnormalized
            for (int i = 0; i <= int'(CSR_HORIZONTAL_SLOPE); i++)
               csr_write(CSR_IDX_W'(i), CSR_DATA_W'({$urandom(), $urandom()}));
         end
         csr_write(CSR_NO_REGISTER, CSR_DATA_W'({$urandom(), $urandom()}));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sphere(random_sphere());
         wait_for_results();
      end
   endtask

   // Receiver stalls per the current idling mode
   always @(posedge clock) begin
      rsp_ready <= (receiver_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= receiver_stall_pct);
   end

   // Check each result item against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (visible_queue.size() == 0) begin
            $error("unexpected result item: visible actual %0b", rsp_visible);
            error_count++;
         end else begin
            want_visible = visible_queue.pop_front();
            if (rsp_visible !== want_visible) begin
               $error("visible: expected %0b, actual %0b", want_visible, rsp_visible);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      cam_reg = CAMERA_RESET;
      fwd_reg = FORWARD_RESET;
      right_reg = RIGHT_RESET;
      up_reg = UP_RESET;
      range_reg = RANGE_RESET;
      vslope_reg = SLOPE_RESET;
      hslope_reg = SLOPE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_depth_planes();
      test_random_settings();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule
